FILE: rtl/core/lspd_pkg.sv
// ---------------------------------------------------------------------------
// lspd_pkg
// Shared widths, codes and control types of the line sensor PD correction
// unit.
// ---------------------------------------------------------------------------
package lspd_pkg;

	localparam int NUM_SENSORS = 14;
	localparam int POS_SCALE   = 100;
	localparam int GAIN_DIV    = 100;

	localparam int READ_W  = 12;
	localparam int IDX_W   = 4;
	localparam int PAT_W   = 14;
	localparam int SUM_W   = 14;
	localparam int CNT_W   = 4;
	localparam int POS_W   = 12;
	localparam int ERR_W   = 12;
	localparam int PROP_W  = 15;
	localparam int DERIV_W = 16;

	localparam int THR_W = 12;
	localparam int CTR_W = 11;
	localparam int GAIN_W = 10;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = IDX_W;
	localparam int M_FIELD_W = PAT_W + POS_W + ERR_W + PROP_W + DERIV_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	// iterative divider: position sum over active count
	localparam int DIV_W     = SUM_W;
	localparam int DVS_W     = CNT_W;
	localparam int DIV_CNT_W = 4;
	localparam int MAG_W     = 12;

	// gain product over 100 by reciprocal multiply, exact for products below 2^22
	localparam int PROD_W     = 22;
	localparam int RCP_W      = 22;
	localparam int RCP_SH     = 28;
	localparam int RCP_FULL_W = PROD_W + RCP_W;
	localparam int CQ_W       = RCP_FULL_W - RCP_SH;

	localparam logic [RCP_W-1:0] RCP_100 = RCP_W'((2**RCP_SH + GAIN_DIV - 1) / GAIN_DIV);

	localparam logic [DIV_W-1:0] POS_MAX       = DIV_W'(2**(POS_W-1) - 1);
	localparam logic [CQ_W-1:0]  PROP_MAX_POS  = CQ_W'(2**(PROP_W-1) - 1);
	localparam logic [CQ_W-1:0]  PROP_MAX_NEG  = CQ_W'(2**(PROP_W-1));
	localparam logic [CQ_W-1:0]  DERIV_MAX_POS = CQ_W'(2**(DERIV_W-1) - 1);
	localparam logic [CQ_W-1:0]  DERIV_MAX_NEG = CQ_W'(2**(DERIV_W-1));

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd3;

	localparam logic [THR_W-1:0]  THR_RST        = 12'd2048;
	localparam logic [CTR_W-1:0]  CENTER_RST     = 11'd650;
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 10'd30;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 10'd0;

	localparam logic MUL_SRC_PROP  = 1'b0;
	localparam logic MUL_SRC_DERIV = 1'b1;

	typedef struct packed {
		logic acc;
		logic div_start;
		logic pos_load;
		logic mul_load;
		logic mul_src;
		logic rcp_load;
		logic prop_load;
		logic deriv_load;
		logic out_load;
	} lspd_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} lspd_sts_t;

endpackage

FILE: rtl/core/line_sensor_pd_correction_unit.sv
// ---------------------------------------------------------------------------
// line_sensor_pd_correction_unit
// Line position from one frame of sensor readings, error against center,
// and proportional and derivative corrections.
// ---------------------------------------------------------------------------
//  channel  handshake          payload
//  s_*      s_tvalid/s_tready  tdata reading, tuser sensor_index, tlast frame_end
//  m_*      m_tvalid/m_tready  tdata pattern, position, error, prop, deriv
//  cfg_*    cfg_valid/ready    cfg_index, cfg_data
//
//  One reading per cycle within a frame. After the frame_end item the input
//  stalls for a bit-serial divide of the position sum by the active count
//  with its start and wait, then multiply, reciprocal scale by 1/100 and
//  load for each correction, then the result write.
//  A waiting result does not stall accumulation of the next frame, only the
//  write of its result. Reset returns registers to their defaults and
//  clears the frame accumulators and the previous error.
// ---------------------------------------------------------------------------
module line_sensor_pd_correction_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lspd_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] reading
	input  logic [lspd_pkg::S_TUSER_W-1:0]    s_tuser,   // [3:0] sensor_index
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [13:0] sensor_pattern, [25:14] line_position, [37:26] line_error,
	// [52:38] prop_correction, [68:53] deriv_correction
	output logic [lspd_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lspd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lspd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lspd_pkg::*;

	lspd_cmd_t cmd;
	lspd_sts_t sts;

	assign cfg_ready = 1'b1;

	lspd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lspd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: rtl/core/lspd_div.sv
// ---------------------------------------------------------------------------
// lspd_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ---------------------------------------------------------------------------
module lspd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lspd_pkg::DIV_W-1:0]   dividend,
	input  logic [lspd_pkg::DVS_W-1:0]   divisor,
	output logic [lspd_pkg::DIV_W-1:0]   quotient,
	output logic                         busy
);
	import lspd_pkg::*;

	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W:0]       trial;
	logic                 ge;
	logic [DVS_W-1:0]     rem_nxt;

	assign trial   = {rem_q, quo_q[DIV_W-1]};
	assign ge      = trial >= {1'b0, dvs_q};
	assign rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient = quo_q;
	assign busy     = cnt_q != '0;

endmodule

FILE: rtl/core/lspd_ctrl.sv
// ---------------------------------------------------------------------------
// lspd_ctrl
// Frame sequencer: accumulate readings, then position divide, gain
// multiplies with reciprocal scaling, and result write.
// ---------------------------------------------------------------------------
module lspd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tlast,
	output logic                 s_tready,
	input  lspd_pkg::lspd_sts_t  sts,
	output lspd_pkg::lspd_cmd_t  cmd
);
	import lspd_pkg::*;

	localparam logic [3:0] ST_ACC    = 4'd0;
	localparam logic [3:0] ST_PSTART = 4'd1;
	localparam logic [3:0] ST_PWAIT  = 4'd2;
	localparam logic [3:0] ST_PMUL   = 4'd3;
	localparam logic [3:0] ST_PRCP   = 4'd4;
	localparam logic [3:0] ST_PCORR  = 4'd5;
	localparam logic [3:0] ST_DMUL   = 4'd6;
	localparam logic [3:0] ST_DRCP   = 4'd7;
	localparam logic [3:0] ST_DCORR  = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_ACC: begin
				cmd.acc = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_nxt = ST_PSTART;
				end
			end
			ST_PSTART: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_PWAIT;
			end
			ST_PWAIT: begin
				if (!sts.div_busy) begin
					cmd.pos_load = 1'b1;
					state_nxt    = ST_PMUL;
				end
			end
			ST_PMUL: begin
				cmd.mul_load = 1'b1;
				cmd.mul_src  = MUL_SRC_PROP;
				state_nxt    = ST_PRCP;
			end
			ST_PRCP: begin
				cmd.rcp_load = 1'b1;
				state_nxt    = ST_PCORR;
			end
			ST_PCORR: begin
				cmd.prop_load = 1'b1;
				state_nxt     = ST_DMUL;
			end
			ST_DMUL: begin
				cmd.mul_load = 1'b1;
				cmd.mul_src  = MUL_SRC_DERIV;
				state_nxt    = ST_DRCP;
			end
			ST_DRCP: begin
				cmd.rcp_load = 1'b1;
				state_nxt    = ST_DCORR;
			end
			ST_DCORR: begin
				cmd.deriv_load = 1'b1;
				state_nxt      = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_ACC;
				end
			end
			default: begin
				state_nxt = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = state_q == ST_ACC;

endmodule

FILE: rtl/core/lspd_dp.sv
// ---------------------------------------------------------------------------
// lspd_dp
// Datapath: config registers, frame accumulators, position and error,
// shared gain multiplier, reciprocal scaling, divider, output register.
// ---------------------------------------------------------------------------
module lspd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lspd_pkg::lspd_cmd_t               cmd,
	output lspd_pkg::lspd_sts_t               sts,
	input  logic [lspd_pkg::S_TDATA_W-1:0]    s_tdata,   // reading
	input  logic [lspd_pkg::S_TUSER_W-1:0]    s_tuser,   // sensor_index
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lspd_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	input  logic [lspd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lspd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lspd_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic [CTR_W-1:0]  center_q;
	logic [GAIN_W-1:0] pgain_q;
	logic [GAIN_W-1:0] dgain_q;

	logic [PAT_W-1:0] pattern_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	logic [POS_W-1:0]   pos_q;
	logic [ERR_W-1:0]   err_q;
	logic [ERR_W-1:0]   last_err_q;
	logic [PROD_W-1:0]  prod_q;
	logic               neg_q;
	logic [CQ_W-1:0]    cq_q;
	logic [PROP_W-1:0]  prop_q;
	logic [DERIV_W-1:0] deriv_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic               m_tvalid_q;

	logic [READ_W-1:0] reading;
	logic [IDX_W-1:0]  idx;
	logic [PAT_W-1:0]  mask;
	logic              hit;

	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic [DIV_W-1:0] quo;
	logic             div_busy;

	logic [POS_W-1:0]        pos_val;
	logic signed [ERR_W:0]   err_wide;
	logic [ERR_W-1:0]        err_val;
	logic signed [ERR_W:0]   diff;
	logic signed [ERR_W:0]   mul_in;
	logic [ERR_W:0]          mul_abs;
	logic [MAG_W-1:0]        mag;
	logic [GAIN_W-1:0]       gain;
	logic [RCP_FULL_W-1:0]   rcp_full;
	logic [CQ_W-1:0]         neg_cq;
	logic [PROP_W-1:0]       prop_val;
	logic [DERIV_W-1:0]      deriv_val;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RST;
			center_q <= CENTER_RST;
			pgain_q  <= PROP_GAIN_RST;
			dgain_q  <= DERIV_GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESHOLD:  thr_q    <= cfg_data[THR_W-1:0];
				CFG_CENTER:     center_q <= cfg_data[CTR_W-1:0];
				CFG_PROP_GAIN:  pgain_q  <= cfg_data[GAIN_W-1:0];
				CFG_DERIV_GAIN: dgain_q  <= cfg_data[GAIN_W-1:0];
			endcase
		end
	end

	// frame accumulation
	assign reading = s_tdata[READ_W-1:0];
	assign idx     = s_tuser;
	assign mask    = PAT_W'(1) << idx;
	assign hit     = (32'(idx) < NUM_SENSORS) && (32'(idx) < PAT_W) &&
	                 (reading > thr_q) && ((pattern_q & mask) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else if (cmd.out_load) begin
			pattern_q <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else if (cmd.acc && hit) begin
			pattern_q <= pattern_q | mask;
			sum_q     <= sum_q + SUM_W'(idx) * SUM_W'(POS_SCALE);
			cnt_q     <= cnt_q + 1'b1;
		end
	end

	// position divider
	assign div_dividend = sum_q;
	assign div_divisor  = cnt_q;

	lspd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quo),
		.busy     (div_busy)
	);

	// position and error
	always_comb begin
		if (cnt_q == '0) begin
			pos_val = '1;
		end else if (quo > POS_MAX) begin
			pos_val = POS_MAX[POS_W-1:0];
		end else begin
			pos_val = quo[POS_W-1:0];
		end
		err_wide = $signed({2'b00, center_q}) - $signed({pos_val[POS_W-1], pos_val});
		if (err_wide > $signed(13'(2**(ERR_W-1) - 1))) begin
			err_val = {1'b0, {(ERR_W-1){1'b1}}};
		end else if (err_wide < -$signed(13'(2**(ERR_W-1)))) begin
			err_val = {1'b1, {(ERR_W-1){1'b0}}};
		end else begin
			err_val = err_wide[ERR_W-1:0];
		end
	end

	// gain multiply on magnitudes, sign kept aside
	always_comb begin
		diff    = $signed({err_q[ERR_W-1], err_q}) - $signed({last_err_q[ERR_W-1], last_err_q});
		mul_in  = (cmd.mul_src == MUL_SRC_PROP) ? $signed({err_q[ERR_W-1], err_q}) : diff;
		gain    = (cmd.mul_src == MUL_SRC_PROP) ? pgain_q : dgain_q;
		mul_abs = mul_in[ERR_W] ? (~mul_in + 1'b1) : mul_in;
		mag     = mul_abs[MAG_W-1:0];
	end

	// product over 100, truncated
	assign rcp_full = RCP_FULL_W'(prod_q) * RCP_FULL_W'(RCP_100);

	// saturated signed corrections from quotient magnitude
	always_comb begin
		neg_cq = ~cq_q + 1'b1;
		if (neg_q) begin
			prop_val  = (cq_q > PROP_MAX_NEG) ? {1'b1, {(PROP_W-1){1'b0}}} :
			            neg_cq[PROP_W-1:0];
			deriv_val = (cq_q > DERIV_MAX_NEG) ? {1'b1, {(DERIV_W-1){1'b0}}} :
			            neg_cq[DERIV_W-1:0];
		end else begin
			prop_val  = (cq_q > PROP_MAX_POS) ? {1'b0, {(PROP_W-1){1'b1}}} :
			            cq_q[PROP_W-1:0];
			deriv_val = (cq_q > DERIV_MAX_POS) ? {1'b0, {(DERIV_W-1){1'b1}}} :
			            cq_q[DERIV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_load) begin
			pos_q <= pos_val;
			err_q <= err_val;
		end
		if (cmd.mul_load) begin
			prod_q <= PROD_W'(mag) * PROD_W'(gain);
			neg_q  <= mul_in[ERR_W];
		end
		if (cmd.rcp_load) begin
			cq_q <= rcp_full[RCP_SH +: CQ_W];
		end
		if (cmd.prop_load) begin
			prop_q <= prop_val;
		end
		if (cmd.deriv_load) begin
			deriv_q <= deriv_val;
		end
		if (cmd.out_load) begin
			m_tdata_q <= M_TDATA_W'({deriv_q, prop_q, err_q, pos_q, pattern_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			last_err_q <= err_q;
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

FILE: tb/sv/line_sensor_pd_correction_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// line_sensor_pd_correction_unit_tb
// Streams sensor frames into the PD correction unit and checks every frame
// result against table values or an in-bench model of pattern, position,
// error and corrections. A directed table covers reset defaults, threshold
// edges, out-of-range and repeated indexes and saturation; random frames
// follow under several register settings and handshake pressure profiles.
// ---------------------------------------------------------------------------
module line_sensor_pd_correction_unit_tb;
	import lspd_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 100;
	localparam int SEG_ITEMS    = 66;

	typedef struct packed {
		logic signed [DERIV_W-1:0] deriv;
		logic signed [PROP_W-1:0]  prop;
		logic signed [ERR_W-1:0]   err;
		logic signed [POS_W-1:0]   pos;
		logic [PAT_W-1:0]          pattern;
	} pd_result_t;

	typedef enum logic [1:0] {ROW_READ, ROW_READ_CHK, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic [READ_W-1:0] reading;
		logic [IDX_W-1:0]  idx;
		logic              last;
		logic [11:0]       thr;
		logic [11:0]       ctr;
		logic [11:0]       pg;
		logic [11:0]       dg;
		pd_result_t        res;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic [S_TUSER_W-1:0]  s_tuser   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// model state and register copies
	logic [THR_W-1:0]  thr_r  = THR_RST;
	logic [CTR_W-1:0]  ctr_r  = CENTER_RST;
	logic [GAIN_W-1:0] pg_r   = PROP_GAIN_RST;
	logic [GAIN_W-1:0] dg_r   = DERIV_GAIN_RST;
	logic [PAT_W-1:0]  seen_mask = '0;
	logic [SUM_W-1:0]  pos_sum   = '0;
	logic [CNT_W-1:0]  hit_count = '0;
	int                prev_error = 0;

	pd_result_t pending_results [$];
	stim_row_t  stim_table [$];
	int         src_idle_pct  = 0;
	int         sink_idle_pct = 0;
	int         fail_count    = 0;
	int         cycle_count   = 0;

	line_sensor_pd_correction_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int saturate(input int v, input int bits);
		int hi;
		int lo;
		hi = (1 << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic bit accumulate_reading(input logic [READ_W-1:0] rd,
			input logic [IDX_W-1:0] ix, input logic lst, output pd_result_t r);
		int pos;
		int err;
		int ctr;
		int pg;
		int dg;
		r = '0;
		if (ix < NUM_SENSORS && ix < PAT_W && rd > thr_r) begin
			if (!seen_mask[ix]) begin
				seen_mask[ix] = 1'b1;
				pos_sum = pos_sum + SUM_W'(ix * POS_SCALE);
				hit_count = hit_count + 1'b1;
			end
		end
		if (!lst) return 1'b0;
		ctr = ctr_r;
		pg = pg_r;
		dg = dg_r;
		if (hit_count == 0)
			pos = -1;
		else
			pos = pos_sum / hit_count;
		pos = saturate(pos, POS_W);
		err = saturate(ctr - pos, ERR_W);
		r.pattern = seen_mask;
		r.pos = pos[POS_W-1:0];
		r.err = err[ERR_W-1:0];
		r.prop = PROP_W'(saturate(err * pg / GAIN_DIV, PROP_W));
		r.deriv = DERIV_W'(saturate((err - prev_error) * dg / GAIN_DIV, DERIV_W));
		prev_error = err;
		seen_mask = '0;
		pos_sum = '0;
		hit_count = '0;
		return 1'b1;
	endfunction

	function automatic stim_row_t reading_row(input int rd, input int ix, input int lst);
		stim_row_t row;
		row = '0;
		row.kind = ROW_READ;
		row.reading = rd[READ_W-1:0];
		row.idx = ix[IDX_W-1:0];
		row.last = lst[0];
		return row;
	endfunction

	function automatic stim_row_t checked_row(input int rd, input int ix, input int lst,
			input int pat, input int pos, input int err, input int prop, input int deriv);
		stim_row_t row;
		row = reading_row(rd, ix, lst);
		row.kind = ROW_READ_CHK;
		row.res.pattern = pat[PAT_W-1:0];
		row.res.pos = pos[POS_W-1:0];
		row.res.err = err[ERR_W-1:0];
		row.res.prop = prop[PROP_W-1:0];
		row.res.deriv = deriv[DERIV_W-1:0];
		return row;
	endfunction

	function automatic stim_row_t config_row(input int thr, input int ctr, input int pg,
			input int dg);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.thr = thr[11:0];
		row.ctr = ctr[11:0];
		row.pg = pg[11:0];
		row.dg = dg[11:0];
		return row;
	endfunction

	function automatic logic [READ_W-1:0] pick_reading();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) return '0;
		if (sel < 20) return '1;
		if (sel < 35) return thr_r;
		if (sel < 50) return (thr_r == '1) ? thr_r : thr_r + 1'b1;
		return READ_W'($urandom_range(4095));
	endfunction

	function automatic void compare_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$error("%s mismatch: expected %0d, got %0d", name, expv, actv);
			fail_count++;
		end
	endfunction

	task automatic send_reading(input logic [READ_W-1:0] rd, input logic [IDX_W-1:0] ix,
			input logic lst, input bit typed, input pd_result_t fixed);
		pd_result_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(rd);
		s_tuser <= ix;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		if (accumulate_reading(rd, ix, lst, predicted))
			pending_results.push_back(typed ? fixed : predicted);
	endtask

	task automatic pause_until_drained(input bit settle);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		if (settle)
			repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_THRESHOLD: thr_r = val[THR_W-1:0];
			CFG_CENTER: ctr_r = val[CTR_W-1:0];
			CFG_PROP_GAIN: pg_r = val[GAIN_W-1:0];
			CFG_DERIV_GAIN: dg_r = val[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [11:0] thr, input logic [11:0] ctr,
			input logic [11:0] pg, input logic [11:0] dg);
		put_reg(CFG_THRESHOLD, thr);
		put_reg(CFG_CENTER, ctr);
		put_reg(CFG_PROP_GAIN, pg);
		put_reg(CFG_DERIV_GAIN, dg);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_frame(inout int counted);
		int order [NUM_SENSORS];
		int n;
		int j;
		int tmp;
		int k;
		bit wellformed;
		logic [IDX_W-1:0] ix;
		wellformed = ($urandom_range(99) < 80);
		for (k = 0; k < NUM_SENSORS; k++)
			order[k] = k;
		for (k = NUM_SENSORS - 1; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		n = wellformed ? $urandom_range(1, NUM_SENSORS) : $urandom_range(1, 8);
		for (k = 0; k < n; k++) begin
			ix = wellformed ? IDX_W'(order[k]) : IDX_W'($urandom_range(15));
			send_reading(pick_reading(), ix, k == n - 1, 1'b0, '0);
			if (ix < NUM_SENSORS || k == n - 1)
				counted++;
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin : result_check
		pd_result_t got;
		pd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[M_FIELD_W-1:0];
			if (pending_results.size() == 0) begin
				$error("result with no expectation waiting: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("sensor_pattern", want.pattern, got.pattern);
				compare_field("line_position", want.pos, got.pos);
				compare_field("line_error", want.err, got.err);
				compare_field("prop_correction", want.prop, got.prop);
				compare_field("deriv_correction", want.deriv, got.deriv);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int k;
		int seg;
		int sent;
		bit paused;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: threshold 2048, center 650, gains 30 / 0
		stim_table.push_back(checked_row(0, 0, 1, 0, -1, 651, 195, 0));
		stim_table.push_back(checked_row(2048, 5, 1, 0, -1, 651, 195, 0));
		stim_table.push_back(checked_row(2049, 0, 1, 14'h0001, 0, 650, 195, 0));
		stim_table.push_back(checked_row(4095, 13, 1, 14'h2000, 1300, -650, -195, 0));
		stim_table.push_back(reading_row(4095, 0, 0));
		stim_table.push_back(checked_row(4095, 13, 1, 14'h2001, 650, 0, 0, 0));
		for (k = 0; k < NUM_SENSORS - 1; k++)
			stim_table.push_back(reading_row(4095, k, 0));
		stim_table.push_back(checked_row(4095, 13, 1, 14'h3FFF, 650, 0, 0, 0));
		// out-of-range indexes, last one still closes the frame
		stim_table.push_back(reading_row(4095, 14, 0));
		stim_table.push_back(checked_row(4095, 15, 1, 0, -1, 651, 195, 0));
		// repeated index counts once
		stim_table.push_back(reading_row(4095, 3, 0));
		stim_table.push_back(reading_row(4095, 3, 0));
		stim_table.push_back(checked_row(4095, 7, 1, 14'h0088, 500, 150, 45, 0));
		// saturation of error and corrections
		stim_table.push_back(config_row(0, 0, 1023, 1023));
		stim_table.push_back(reading_row(4095, 13, 1));
		stim_table.push_back(config_row(4095, 2047, 1023, 1023));
		stim_table.push_back(checked_row(4095, 0, 1, 0, -1, 2047, 16383, 32767));
		stim_table.push_back(config_row(0, 0, 1023, 1023));
		stim_table.push_back(checked_row(4095, 13, 1, 14'h2000, 1300, -1300, -13299, -32768));

		src_idle_pct = 36;
		sink_idle_pct = 62;
		foreach (stim_table[k]) begin
			row = stim_table[k];
			if (row.kind == ROW_CFG) begin
				pause_until_drained(1'b1);
				load_settings(row.thr, row.ctr, row.pg, row.dg);
			end else begin
				send_reading(row.reading, row.idx, row.last, row.kind == ROW_READ_CHK, row.res);
			end
		end

		for (seg = 0; seg < 6; seg++) begin
			if (seg < 2) begin
				src_idle_pct = 36;
				sink_idle_pct = 62;
			end else if (seg < 4) begin
				src_idle_pct = 62;
				sink_idle_pct = 36;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			pause_until_drained(1'b1);
			case (seg)
				2: load_settings('0, '0, '0, '0);
				3: load_settings(12'd4095, 12'd2047, 12'd1023, 12'd1023);
				5: load_settings(THR_RST, CENTER_RST, PROP_GAIN_RST, DERIV_GAIN_RST);
				default: load_settings(12'($urandom_range(4095)), 12'($urandom_range(1300)),
					12'($urandom_range(1000)), 12'($urandom_range(1000)));
			endcase
			sent = 0;
			paused = 1'b0;
			while (sent < SEG_ITEMS) begin
				send_random_frame(sent);
				if (!paused && sent >= SEG_ITEMS / 2) begin
					pause_until_drained(1'b0);
					paused = 1'b1;
				end
			end
		end

		pause_until_drained(1'b1);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
